>>> rtl/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

   // Width of the occupancy and capacity fields on the ports
   localparam int unsigned CNT_BITS = 9;

   // Capacity register value after reset
   localparam logic [CNT_BITS-1:0] CAP_RESET = 9'd256;

   // Request kinds carried on req_tuser
   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   // Operation broadcast to every cell of the row
   typedef struct packed {
      logic ins;   // insert the new item at its sorted place
      logic del;   // shift the row one place toward the head
   } cell_op_type;

endpackage

`default_nettype wire

>>> rtl/mpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted row. Holds a key and a tag, compares its key with
// the broadcast key and hands its contents to the neighbor on a shift.
module mpq_cell #(
   parameter int unsigned KEY_BITS = 32,
   parameter int unsigned TAG_BITS = 9
) (
   input  wire                       clock,
   input  mpq_pkg::cell_op_type      op,
   input  wire  [KEY_BITS-1:0]       new_key,
   input  wire  [TAG_BITS-1:0]       new_tag,
   input  wire                       present,       // slot holds a live item
   input  wire  [KEY_BITS-1:0]       left_key,
   input  wire  [TAG_BITS-1:0]       left_tag,
   input  wire                       left_greater,
   input  wire  [KEY_BITS-1:0]       right_key,
   input  wire  [TAG_BITS-1:0]       right_tag,
   output logic [KEY_BITS-1:0]       key,
   output logic [TAG_BITS-1:0]       tag,
   output logic                      greater         // new item goes at or before here
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   // empty slots count as greater so the insert point is at or before the first of them
   assign greater = !present || (key_ff > new_key);

   // next contents: take left neighbor, take new item, take right neighbor, or hold
   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      priority if (op.ins && greater && left_greater) begin
         key_in = left_key;
         tag_in = left_tag;
      end else if (op.ins && greater) begin
         key_in = new_key;
         tag_in = new_tag;
      end else if (op.del) begin
         key_in = right_key;
         tag_in = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key = key_ff;
   assign tag = tag_ff;

endmodule

`default_nettype wire

>>> rtl/min_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted minimum priority queue built as a row of DEPTH cells. An enqueue beat
// (req_tuser = 0) inserts its key and tag after all held items with a smaller
// or equal key, so equal keys leave in arrival order; a dequeue beat
// (req_tuser = 1) removes and returns the head item. Every request gives one
// response beat with the ok flag on rsp_tuser and the count, empty and full
// status after the request. Enqueue is rejected at capacity (csr_wr_data,
// clamped into 1..DEPTH), dequeue when empty. Throughput is one request per
// clock while rsp_tready keeps up: all cells compare with the new key in the
// same cycle and shift by at most one place; the response is registered and
// shows in the cycle after acceptance. Write the capacity only while idle.
module min_priority_queue #(
   parameter int unsigned DEPTH    = 256,
   parameter int unsigned KEY_BITS = 32,
   parameter int unsigned TAG_BITS = 9,
   localparam int unsigned REQ_W   = ((KEY_BITS + TAG_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_W   =
      ((KEY_BITS + TAG_BITS + mpq_pkg::CNT_BITS + 2 + 7) / 8) * 8
) (
   input  wire                         clock,
   input  wire                         reset,
   // capacity register
   input  wire                         csr_wr_en,
   input  wire  [mpq_pkg::CNT_BITS-1:0] csr_wr_data,
   // request channel
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [REQ_W-1:0]            req_tdata,    // item_key, item_tag
   input  wire                         req_tuser,    // req_type
   // response channel
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [RSP_W-1:0]            rsp_tdata,    // out_key, out_tag, entry_count,
                                                     // is_empty, is_full
   output logic                        rsp_tuser     // ok
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W = (CNT_W > mpq_pkg::CNT_BITS) ? CNT_W : mpq_pkg::CNT_BITS;

   // capacity register
   logic [mpq_pkg::CNT_BITS-1:0] cap_ff, cap_in;

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= mpq_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // effective capacity clamped into 1..DEPTH
   logic [CMP_W-1:0] cap_ext, eff_cap;

   assign cap_ext = CMP_W'(cap_ff);

   always_comb begin
      eff_cap = cap_ext;
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end
   end

   // request decode
   logic                accept;
   logic [KEY_BITS-1:0] new_key;
   logic [TAG_BITS-1:0] new_tag;
   logic                is_enq, is_deq;

   assign req_tready = !rsp_tvalid || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign new_key    = req_tdata[KEY_BITS-1:0];
   assign new_tag    = req_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS];
   assign is_enq     = (req_tuser == mpq_pkg::REQ_ENQUEUE);
   assign is_deq     = (req_tuser == mpq_pkg::REQ_DEQUEUE);

   // occupancy
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CMP_W-1:0] count_ext;
   logic             enq_ok, deq_ok;

   assign count_ext = CMP_W'(count_ff);
   assign enq_ok    = accept && is_enq && (count_ext < eff_cap);
   assign deq_ok    = accept && is_deq && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      priority if (enq_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // row of cells, head at index 0
   mpq_pkg::cell_op_type op;
   logic [KEY_BITS-1:0]  cell_key     [DEPTH];
   logic [TAG_BITS-1:0]  cell_tag     [DEPTH];
   logic                 cell_greater [DEPTH];

   assign op = '{ins: enq_ok, del: deq_ok};

   for (genvar i = 0; i < DEPTH; i++) begin : g_row
      logic [KEY_BITS-1:0] lkey, rkey;
      logic [TAG_BITS-1:0] ltag, rtag;
      logic                lgreater;
      logic                present;

      assign present = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign lkey     = '0;
         assign ltag     = '0;
         assign lgreater = 1'b0;
      end else begin : g_mid
         assign lkey     = cell_key[i-1];
         assign ltag     = cell_tag[i-1];
         assign lgreater = cell_greater[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign rkey = '0;
         assign rtag = '0;
      end else begin : g_body
         assign rkey = cell_key[i+1];
         assign rtag = cell_tag[i+1];
      end

      mpq_cell #(
         .KEY_BITS (KEY_BITS),
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock        (clock),
         .op           (op),
         .new_key      (new_key),
         .new_tag      (new_tag),
         .present      (present),
         .left_key     (lkey),
         .left_tag     (ltag),
         .left_greater (lgreater),
         .right_key    (rkey),
         .right_tag    (rtag),
         .key          (cell_key[i]),
         .tag          (cell_tag[i]),
         .greater      (cell_greater[i])
      );
   end

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         ok_ff, ok_in;
   logic [KEY_BITS-1:0]          okey_ff, okey_in;
   logic [TAG_BITS-1:0]          otag_ff, otag_in;
   logic [mpq_pkg::CNT_BITS-1:0] ocnt_ff, ocnt_in;
   logic                         empty_ff, empty_in;
   logic                         full_ff, full_in;
   logic [CMP_W-1:0]             next_ext;

   assign next_ext = CMP_W'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      ok_in    = enq_ok || deq_ok;
      okey_in  = deq_ok ? cell_key[0] : '0;
      otag_in  = deq_ok ? cell_tag[0] : '0;
      ocnt_in  = next_ext[mpq_pkg::CNT_BITS-1:0];
      empty_in = (count_in == '0);
      full_in  = (next_ext >= eff_cap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload loads on each accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff    <= ok_in;
         okey_ff  <= okey_in;
         otag_ff  <= otag_in;
         ocnt_ff  <= ocnt_in;
         empty_ff <= empty_in;
         full_ff  <= full_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = ok_ff;
   assign rsp_tdata  = RSP_W'({full_ff, empty_ff, ocnt_ff, otag_ff, okey_ff});

endmodule

`default_nettype wire
